>>> sv/fts_pkg.sv
// Shared constants and types for the float to fixed-point converter.
`timescale 1ns / 1ps

package fts_pkg;

  localparam int DATA_WIDTH_DEF = 16;  // default output word width
  localparam int CFG_W          = 4;   // width of the integer-bits register
  localparam int FLOAT_W        = 32;  // single-precision word
  localparam int MANT_W         = 24;  // mantissa with hidden bit
  localparam int EXP_W          = 8;
  localparam int FRAC_W         = 23;
  localparam int K_W            = 11;  // signed shift amount width
  localparam int SHIFT_W        = 5;   // barrel shift select width
  localparam int MAX_RSHIFT     = 25;  // beyond this the value rounds to zero
  localparam int EXP_OFFSET     = 150; // bias plus mantissa fraction width
  localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'hFF;

  typedef struct packed {
    logic [DATA_WIDTH_DEF-1:0] code;
    logic                      sat;
  } fts_result_def_t;

endpackage

>>> sv/fts_convert.sv
// Combinational conversion of one single-precision word to a saturated fixed-point code.
`timescale 1ns / 1ps

module fts_convert #(
  parameter int DATA_WIDTH = fts_pkg::DATA_WIDTH_DEF
) (
  input  logic [fts_pkg::FLOAT_W-1:0] float_bits,
  input  logic [fts_pkg::CFG_W-1:0]   integer_bits,
  output logic [DATA_WIDTH-1:0]       fixed_value,
  output logic                        saturated
);
  import fts_pkg::*;

  localparam int CW     = MANT_W + DATA_WIDTH;
  localparam int IB_MAX = DATA_WIDTH - 1;
  localparam int RW     = MANT_W + 2;

  logic                neg;
  logic [EXP_W-1:0]    expf;
  logic [FRAC_W-1:0]   frac;
  logic [MANT_W-1:0]   mant;
  logic [EXP_W:0]      exp_eff;
  logic [SHIFT_W-1:0]  ib_eff;
  logic [SHIFT_W-1:0]  fbits;
  logic signed [K_W-1:0] k;
  logic signed [K_W-1:0] s;
  logic [SHIFT_W-1:0]  sh;
  logic [CW-1:0]       lim;
  logic [CW-1:0]       bound;
  logic [CW-1:0]       shl;
  logic [CW-1:0]       q;
  logic [RW-1:0]       rem;
  logic [RW-1:0]       half;
  logic [CW-1:0]       mag;
  logic [CW-1:0]       code;
  logic                sat;

  always_comb begin
    neg     = float_bits[FLOAT_W-1];
    expf    = float_bits[FLOAT_W-2 -: EXP_W];
    frac    = float_bits[FRAC_W-1:0];
    mant    = (expf == '0) ? {1'b0, frac} : {1'b1, frac};
    exp_eff = (expf == '0) ? (EXP_W+1)'(1) : {1'b0, expf};
    ib_eff  = ({1'b0, integer_bits} > SHIFT_W'(IB_MAX)) ? SHIFT_W'(IB_MAX)
                                                        : SHIFT_W'(integer_bits);
    fbits   = SHIFT_W'(IB_MAX) - ib_eff;
    k       = $signed(K_W'(exp_eff)) + $signed(K_W'(fbits)) - K_W'(EXP_OFFSET);
    s       = -k;
    lim     = CW'(1) << IB_MAX;
    bound   = neg ? lim : lim - CW'(1);
    sh      = s[SHIFT_W-1:0];
    shl     = CW'(mant) << k[SHIFT_W-1:0];
    q       = CW'(mant >> sh);
    rem     = RW'(mant) & ((RW'(1) << sh) - RW'(1));
    half    = RW'(1) << (sh - SHIFT_W'(1));
    mag     = '0;
    sat     = 1'b0;

    if (mant == '0) begin
      mag = '0;
    end else if (k >= 0) begin
      if (k > K_W'(IB_MAX)) begin
        sat = 1'b1;
      end else begin
        mag = shl;
        sat = shl > bound;
      end
    end else if (s > K_W'(MAX_RSHIFT)) begin
      mag = '0;
    end else if (q > bound || (q == bound && rem != '0)) begin
      sat = 1'b1;
    end else if (rem > half || (rem == half && q[0])) begin
      mag = q + CW'(1);
    end else begin
      mag = q;
    end

    if (sat) code = neg ? (CW'(0) - lim) : (lim - CW'(1));
    else     code = neg ? (CW'(0) - mag) : mag;

    if (expf == EXP_SPECIAL) begin
      if (frac != '0) begin
        code = '0;
        sat  = 1'b0;
      end else begin
        code = neg ? (CW'(0) - lim) : (lim - CW'(1));
        sat  = 1'b1;
      end
    end

    fixed_value = code[DATA_WIDTH-1:0];
    saturated   = sat;
  end

endmodule

>>> sv/float_to_fixed_saturating_unit.sv
// Top level: streaming float32 to saturated fixed-point converter.
`timescale 1ns / 1ps
//
//  channel   direction  payload (lowest bit up)                   handshake
//  s_axis    in         tdata: float_bits[31:0]                   tvalid/tready
//  m_axis    out        tdata: fixed_value[DATA_WIDTH-1:0], zeros tvalid/tready
//                       tuser: saturated
//  cfg       in         cfg_data: integer_bits[3:0]               cfg_we
//
//  One transaction per cycle sustained while m_axis accepts; data passes an input
//  register, then a result register, with the conversion logic between them.
//  Reset (rst, synchronous) empties both stages and sets integer_bits to 0.
//  A stall on m_axis holds the result; the input stage still takes a transaction
//  whenever the result register frees in the same cycle.

module float_to_fixed_saturating_unit #(
  parameter int DATA_WIDTH = fts_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fts_pkg::CFG_W-1:0]           cfg_data,   // integer_bits
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fts_pkg::FLOAT_W-1:0]         s_axis_tdata, // float_bits
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata, // fixed_value, zero pad
  output logic                                m_axis_tuser  // saturated
);
  import fts_pkg::*;

  localparam int ODW = ((DATA_WIDTH + 7) / 8) * 8;

  logic [CFG_W-1:0]      integer_bits;
  logic                  in_valid;
  logic [FLOAT_W-1:0]    in_data;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_code;
  logic                  out_sat;
  logic [DATA_WIDTH-1:0] conv_code;
  logic                  conv_sat;
  logic                  out_adv;
  logic                  in_adv;

  // Result register frees when empty or drained this cycle.
  assign out_adv       = !out_valid || m_axis_tready;
  assign in_adv        = !in_valid || out_adv;
  assign s_axis_tready = in_adv;

  fts_convert #(.DATA_WIDTH(DATA_WIDTH)) u_convert (
    .float_bits   (in_data),
    .integer_bits (integer_bits),
    .fixed_value  (conv_code),
    .saturated    (conv_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      integer_bits <= '0;
    end else if (cfg_we) begin
      integer_bits <= cfg_data;
    end
  end

  // Input stage: take a new transaction whenever the stage moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_adv) begin
      in_valid <= s_axis_tvalid;
    end
    if (in_adv && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  // Result stage: capture the converted word, hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
    if (out_adv && in_valid) begin
      out_code <= conv_code;
      out_sat  <= conv_sat;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = ODW'(out_code);
  assign m_axis_tuser  = out_sat;

  // A clamped result carries one of the two limit codes.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (out_code == {1'b0, {(DATA_WIDTH-1){1'b1}}}) ||
      (out_code == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
    else $error("saturated result is not a limit code");

  // A held input item moves into the result register when it frees.
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_adv |=> out_valid)
    else $error("input stage item lost");

  // A blocked input stage keeps its item.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_adv |=> in_valid && $stable(in_data))
    else $error("input stage changed while blocked");

endmodule

>>> tb/sv/tb_float_to_fixed_saturating_unit.sv
// Self-checking testbench for the float32 to saturated fixed-point converter.
`timescale 1ns / 1ps

module tb_float_to_fixed_saturating_unit;
  import fts_pkg::*;

  localparam int DW       = DATA_WIDTH_DEF;
  localparam int TDATA_W  = ((DW + 7) / 8) * 8;
  localparam int WDOG_MAX = 5000;
  localparam int N_RANDOM = 500;
  localparam int N_DIR    = 22;

  // Idling phases for the random part
  typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_phase_e;

  typedef struct packed {
    logic [DW-1:0] code;
    logic          sat;
  } conv_result_t;

  // Directed stimulus row: setting, input word, and an optional typed-in result
  typedef struct {
    logic [CFG_W-1:0]   ib;
    logic [FLOAT_W-1:0] word;
    bit                 fixed;
    conv_result_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [FLOAT_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  conv_result_t expected_q[$];
  logic [CFG_W-1:0] int_bits;
  idle_phase_e phase = PH_NONE;
  bit hold_off = 1'b0;
  int errors = 0;
  int wdog = 0;
  dir_row_t dir_rows[N_DIR];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  float_to_fixed_saturating_unit #(.DATA_WIDTH(DW)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Exact conversion: scale by 2^F, round half to even, clamp
  function automatic conv_result_t convert_float(logic [FLOAT_W-1:0] word,
                                                 logic [CFG_W-1:0] ib_cfg);
    conv_result_t r;
    bit neg;
    int expo, fb, k, sh, ib;
    logic [63:0] mant, mag, q, rem, half, lim, bound;
    bit sat;
    neg = word[31];
    expo = word[30:23];
    ib = (ib_cfg > DW - 1) ? DW - 1 : ib_cfg;
    fb = DW - 1 - ib;
    lim = 64'd1 << (DW - 1);
    bound = neg ? lim : lim - 1;
    mag = 0;
    sat = 1'b0;
    if (expo == EXP_SPECIAL) begin
      if (word[FRAC_W-1:0] != 0) begin
        r.code = '0;
        r.sat = 1'b0;
        return r;
      end
      sat = 1'b1;
    end else begin
      if (expo == 0) begin
        mant = word[FRAC_W-1:0];
        expo = 1;
      end else begin
        mant = {1'b1, word[FRAC_W-1:0]};
      end
      k = expo - EXP_OFFSET + fb;
      if (mant == 0) begin
        mag = 0;
      end else if (k >= 0) begin
        if (k > 39) begin
          sat = 1'b1;
        end else begin
          mag = mant << k;
          if (mag > bound) sat = 1'b1;
        end
      end else begin
        sh = -k;
        if (sh <= MAX_RSHIFT) begin
          q = mant >> sh;
          rem = mant & ((64'd1 << sh) - 1);
          half = 64'd1 << (sh - 1);
          if (q > bound || (q == bound && rem != 0)) begin
            sat = 1'b1;
          end else begin
            mag = q;
            if (rem > half || (rem == half && q[0])) mag = q + 1;
          end
        end
      end
    end
    if (sat) mag = neg ? -lim : lim - 1;
    else if (neg) mag = -mag;
    r.code = mag[DW-1:0];
    r.sat = sat;
    return r;
  endfunction

  // Receiver: stall according to phase, or hold off completely
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (phase == PH_SNK) begin
      m_axis_tready <= ($urandom_range(99) >= 79);
    end else if (phase == PH_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 27);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker and stall watchdog
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst) begin
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction, fixed_value %0h", m_axis_tdata[DW-1:0]);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[DW-1:0] !== want.code) begin
            $error("fixed_value: expected %0h, got %0h", want.code, m_axis_tdata[DW-1:0]);
            errors++;
          end
          if (m_axis_tuser !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, m_axis_tuser);
            errors++;
          end
          if ((m_axis_tdata >> DW) !== '0) begin
            $error("tdata padding: expected 0, got %0h", m_axis_tdata >> DW);
            errors++;
          end
        end
      end
    end
  end

  // Offer one transaction and hold it until the handshake completes
  task automatic send_float(logic [FLOAT_W-1:0] word, bit fixed, conv_result_t res);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    expected_q.push_back(fixed ? res : convert_float(word, int_bits));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid, idle per phase; only lower valid when a gap is actually taken
  task automatic source_gap();
    int pct;
    pct = (phase == PH_SRC) ? 79 : (phase == PH_BOTH) ? 27 : 0;
    while ($urandom_range(99) < pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_int_bits(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    int_bits = v;
  endtask

  // Random word: mostly exponents near the interesting range, some wild ones
  function automatic logic [FLOAT_W-1:0] rand_float();
    logic [FLOAT_W-1:0] w;
    int n;
    w = $urandom;
    case ($urandom_range(9))
      0: w[30:23] = EXP_SPECIAL;
      1: w[30:23] = 8'h00;
      2, 3: ;
      default: w[30:23] = EXP_W'($urandom_range(100, 150));
    endcase
    // Clear a run of low mantissa bits to make ties and exact values likely
    if ($urandom_range(7) == 0) begin
      n = FRAC_W - int'($urandom_range(1, 12));
      w = w & ~((FLOAT_W'(1) << n) - FLOAT_W'(1));
    end
    return w;
  endfunction

  initial begin
    conv_result_t r_pmax, r_nmin, r_zero, r_none;
    r_pmax = '{code: {1'b0, {(DW-1){1'b1}}}, sat: 1'b1};
    r_nmin = '{code: {1'b1, {(DW-1){1'b0}}}, sat: 1'b1};
    r_zero = '{code: '0, sat: 1'b0};
    r_none = r_zero;
    // Q15 extremes and special encodings, then rows with 15 and 7 integer bits
    dir_rows[0]  = '{4'd0,  32'h0000_0000, 1, r_zero};   // +0
    dir_rows[1]  = '{4'd0,  32'h8000_0000, 1, r_zero};   // -0
    dir_rows[2]  = '{4'd0,  32'h7F80_0000, 1, r_pmax};   // +inf
    dir_rows[3]  = '{4'd0,  32'hFF80_0000, 1, r_nmin};   // -inf
    dir_rows[4]  = '{4'd0,  32'h7FC0_0000, 1, r_zero};   // quiet NaN
    dir_rows[5]  = '{4'd0,  32'hFF80_0001, 1, r_zero};   // negative NaN
    dir_rows[6]  = '{4'd0,  32'h7FFF_FFFF, 1, r_zero};   // NaN, full payload
    dir_rows[7]  = '{4'd0,  32'h3F80_0000, 1, r_pmax};   // 1.0 clamps in Q15
    dir_rows[8]  = '{4'd0,  32'hBF80_0000, 1, '{code: {1'b1, {(DW-1){1'b0}}}, sat: 1'b0}};
    dir_rows[9]  = '{4'd0,  32'h0000_0001, 1, r_zero};   // smallest subnormal
    dir_rows[10] = '{4'd0,  32'h807F_FFFF, 1, r_zero};   // largest negative subnormal
    dir_rows[11] = '{4'd0,  32'h3F7F_FF00, 0, r_none};   // half LSB above top code
    dir_rows[12] = '{4'd0,  32'h3F7F_FE00, 0, r_none};   // just below it
    dir_rows[13] = '{4'd0,  32'h3800_0000, 0, r_none};   // exactly one LSB
    dir_rows[14] = '{4'd0,  32'h38C0_0000, 0, r_none};   // exactly three LSBs
    dir_rows[15] = '{4'd0,  32'h7F7F_FFFF, 1, r_pmax};   // max finite
    dir_rows[16] = '{4'd15, 32'h46FF_FE00, 0, r_none};   // 32767.0, integer only
    dir_rows[17] = '{4'd15, 32'h4700_0000, 1, r_pmax};   // 32768.0 clamps
    dir_rows[18] = '{4'd15, 32'hC700_0000, 1, '{code: {1'b1, {(DW-1){1'b0}}}, sat: 1'b0}};
    dir_rows[19] = '{4'd15, 32'h3F00_0000, 0, r_none};   // 0.5 tie to 0
    dir_rows[20] = '{4'd7,  32'hC2FF_0001, 0, r_none};
    dir_rows[21] = '{4'd7,  32'h4300_0000, 1, r_pmax};

    int_bits = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].ib != int_bits) write_int_bits(dir_rows[i].ib);
      send_float(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].res);
    end

    // Receiver holds off while the sender keeps offering, so the pipe fills
    drain();
    hold_off = 1'b1;
    fork
      begin
        repeat (40) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_float(rand_float(), 0, r_none);
    join
    // Sender pauses until every expected result has come
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) begin
        phase = idle_phase_e'((i / 50) % 4);
        case ((i / 50) % 5)
          0: write_int_bits(4'd0);
          1: write_int_bits(4'd15);
          default: write_int_bits(CFG_W'($urandom_range(15)));
        endcase
      end
      source_gap();
      send_float(rand_float(), 0, r_none);
    end
    s_axis_tvalid <= 1'b0;
    phase = PH_NONE;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
